>>> hw/rtl/isotp_tx_segmenter_unit_macros.svh
// Assertion macros for the ISO-TP transmit segmenter.
// Included by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef ISOTP_TX_SEGMENTER_UNIT_MACROS_SVH
`define ISOTP_TX_SEGMENTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define ISTX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("istx: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ISTX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("istx: next-cycle check failed");

`else

`define ISTX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ISTX_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/istx_pkg.sv
// Types and constants for the ISO-TP transmit segmenter.
// No dependencies; imported by isotp_tx_segmenter_unit.
package istx_pkg;

    localparam int ActionW  = 2;
    localparam int LenW     = 13;
    localparam int RemW     = 12;
    localparam int KindW    = 3;
    localparam int PhaseW   = 3;
    localparam int FillW    = 3;
    localparam int BufDepth = 7;
    localparam int IdW      = 11;
    localparam int DlcW     = 5;
    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 32;

    // input actions
    localparam logic [ActionW-1:0] ACT_START = 2'd0;
    localparam logic [ActionW-1:0] ACT_BYTE  = 2'd1;
    localparam logic [ActionW-1:0] ACT_FC    = 2'd2;

    // result kinds
    localparam logic [KindW-1:0] KIND_SINGLE  = 3'd0;
    localparam logic [KindW-1:0] KIND_FIRST   = 3'd1;
    localparam logic [KindW-1:0] KIND_CONSEC  = 3'd2;
    localparam logic [KindW-1:0] KIND_REJECT  = 3'd3;
    localparam logic [KindW-1:0] KIND_OVERRUN = 3'd4;

    // phases
    localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
    localparam logic [PhaseW-1:0] PH_SF_FILL = 3'd1;
    localparam logic [PhaseW-1:0] PH_FF_FILL = 3'd2;
    localparam logic [PhaseW-1:0] PH_WAIT_FC = 3'd3;
    localparam logic [PhaseW-1:0] PH_SEND    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_TARGET_ID = 2'd0;
    localparam logic [1:0] REG_DLC_CODE  = 2'd1;
    localparam logic [1:0] REG_PAD_BYTE  = 2'd2;

    // PCI nibbles
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;
    localparam logic [3:0] PCI_FC = 4'h3;

    localparam logic [IdW-1:0]  TARGET_ID_RST = 11'd0;
    localparam logic [DlcW-1:0] DLC_CODE_RST  = 5'd8;
    localparam logic [7:0]      PAD_BYTE_RST  = 8'hCC;
    localparam logic [3:0]      SEQ_RST       = 4'd1;
    localparam logic [FillW-1:0] FF_DATA_BYTES = 3'd6;
    localparam logic [FillW-1:0] CF_DATA_BYTES = 3'd7;

    typedef struct packed {
        logic [15:0]     id_word;
        logic [7:0][7:0] data;
        logic [KindW-1:0] kind;
        logic            last;
    } t_frame;

endpackage

>>> hw/rtl/isotp_tx_segmenter_unit.sv
// ISO-TP transmit segmenter: splits a message into single, first and consecutive frames.
// Depends on istx_pkg and isotp_tx_segmenter_unit_macros.svh.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one word per cycle while o_in_ready is high:
//   a start with the message length, a payload byte, or a received flow control frame.
//   Output channel (o_out_valid / i_out_ready) carries complete CAN frames plus reject and
//   overrun notices; at most one result per input word.
//   The user must write the APB configuration only while the block is idle; not enforced.
// Timing
//   Each word is handled in the cycle it is accepted; its result goes to the output
//   register, or to the skid register while the receiver holds off. One word is taken
//   per cycle while o_in_ready is high; a single pass of logic per word updates all state.
// Stall
//   While the receiver holds off, one further result is caught in a skid register;
//   o_in_ready falls only while that skid register is occupied.
// Reset
//   Synchronous, active low: segmentation state returns to idle, sequence number to one,
//   both output stages empty, configuration to target 0, DLC 8, pad 0xCC.
`include "isotp_tx_segmenter_unit_macros.svh"

module isotp_tx_segmenter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [istx_pkg::ApbAddrW-1:0]      paddr,
    input  logic [istx_pkg::ApbDataW-1:0]      pwdata,
    output logic [istx_pkg::ApbDataW-1:0]      prdata,
    output logic                               pready,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [istx_pkg::ActionW-1:0]       i_action,
    input  logic [istx_pkg::LenW-1:0]          i_msg_length,
    input  logic [7:0]                         i_data_byte,
    input  logic [7:0]                         i_fc_first_byte,
    input  logic [7:0]                         i_fc_block_size,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [15:0]                        o_id_word,
    output logic [7:0]                         o_byte0,
    output logic [7:0]                         o_byte1,
    output logic [7:0]                         o_byte2,
    output logic [7:0]                         o_byte3,
    output logic [7:0]                         o_byte4,
    output logic [7:0]                         o_byte5,
    output logic [7:0]                         o_byte6,
    output logic [7:0]                         o_byte7,
    output logic [istx_pkg::KindW-1:0]         o_frame_kind,
    output logic                               o_last
);

    import istx_pkg::*;

    // configuration
    logic [IdW-1:0]  r_target_id;
    logic [DlcW-1:0] r_dlc_code;
    logic [7:0]      r_pad_byte;

    // segmentation state
    logic [7:0]        r_buf [BufDepth];
    logic [FillW-1:0]  r_fill, n_fill;
    logic [RemW-1:0]   r_rem, n_rem;
    logic [PhaseW-1:0] r_phase, n_phase;
    logic [3:0]        r_seq, n_seq;
    logic [7:0]        r_blk_limit, n_blk_limit;
    logic [7:0]        r_blk_count, n_blk_count;
    logic              r_pending, n_pending;

    // output register and skid stage
    t_frame r_out, r_skid;
    logic   r_out_valid, r_skid_valid;

    logic   in_acc;
    logic   buf_wr;
    logic   res_valid;
    t_frame res;

    // consecutive-frame emission inputs
    logic             do_cf;
    logic [FillW-1:0] cf_fill;
    logic [7:0]       cf_buf [BufDepth];
    logic [7:0]       cf_limit;
    logic [7:0]       cf_count;
    logic [FillW-1:0] chunk;
    logic [7:0]       v_buf [BufDepth];
    logic [FillW-1:0] v_fill;
    logic [15:0]      id_word;

    assign pready      = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign id_word     = {r_target_id, r_dlc_code};
    assign chunk       = (r_rem < RemW'(CF_DATA_BYTES)) ? r_rem[FillW-1:0] : CF_DATA_BYTES;
    assign v_fill      = r_fill + FillW'(1);

    always_comb begin
        for (int i = 0; i < BufDepth; i++) begin
            v_buf[i] = (FillW'(i) == r_fill) ? i_data_byte : r_buf[i];
        end
    end

    // APB
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= TARGET_ID_RST;
            r_dlc_code  <= DLC_CODE_RST;
            r_pad_byte  <= PAD_BYTE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_TARGET_ID: r_target_id <= pwdata[IdW-1:0];
                REG_DLC_CODE:  r_dlc_code  <= pwdata[DlcW-1:0];
                REG_PAD_BYTE:  r_pad_byte  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TARGET_ID: prdata = ApbDataW'(r_target_id);
            REG_DLC_CODE:  prdata = ApbDataW'(r_dlc_code);
            REG_PAD_BYTE:  prdata = ApbDataW'(r_pad_byte);
            default:       prdata = '0;
        endcase
    end

    // one pass of segmentation logic per accepted word
    always_comb begin
        n_fill      = r_fill;
        n_rem       = r_rem;
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_blk_limit = r_blk_limit;
        n_blk_count = r_blk_count;
        n_pending   = r_pending;
        buf_wr      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        do_cf       = 1'b0;
        cf_fill     = v_fill;
        cf_buf      = v_buf;
        cf_limit    = r_blk_limit;
        cf_count    = r_blk_count;

        case (i_action)
            ACT_START: begin
                n_fill      = '0;
                n_pending   = 1'b0;
                n_seq       = SEQ_RST;
                n_blk_limit = '0;
                n_blk_count = '0;
                if (i_msg_length == '0 || i_msg_length[LenW-1]) begin
                    n_phase   = PH_IDLE;
                    n_rem     = '0;
                    res_valid = 1'b1;
                    res.kind  = KIND_REJECT;
                end else begin
                    n_rem   = i_msg_length[RemW-1:0];
                    n_phase = (i_msg_length <= LenW'(CF_DATA_BYTES)) ? PH_SF_FILL
                                                                     : PH_FF_FILL;
                end
            end
            ACT_BYTE: begin
                if (r_phase == PH_IDLE || r_pending) begin
                    // stray or overrun: drop the byte
                    res_valid = 1'b1;
                    res.kind  = KIND_OVERRUN;
                end else begin
                    buf_wr = (r_fill < CF_DATA_BYTES);
                    n_fill = v_fill;
                    if (r_phase == PH_SF_FILL) begin
                        if (RemW'(v_fill) >= r_rem) begin
                            res_valid   = 1'b1;
                            res.id_word = id_word;
                            res.kind    = KIND_SINGLE;
                            res.last    = 1'b1;
                            res.data[0] = {4'h0, r_rem[3:0]};
                            for (int i = 0; i < BufDepth; i++) begin
                                res.data[i+1] = (FillW'(i) < v_fill) ? v_buf[i] : r_pad_byte;
                            end
                            n_phase = PH_IDLE;
                            n_rem   = '0;
                            n_fill  = '0;
                        end
                    end else if (r_phase == PH_FF_FILL) begin
                        if (v_fill >= FF_DATA_BYTES) begin
                            res_valid   = 1'b1;
                            res.id_word = id_word;
                            res.kind    = KIND_FIRST;
                            res.data[0] = {PCI_FF, r_rem[11:8]};
                            res.data[1] = r_rem[7:0];
                            for (int i = 0; i < 6; i++) begin
                                res.data[i+2] = v_buf[i];
                            end
                            n_rem   = r_rem - RemW'(FF_DATA_BYTES);
                            n_fill  = '0;
                            n_phase = PH_WAIT_FC;
                        end
                    end else if (v_fill >= chunk) begin
                        // consecutive frame complete: send now or hold for flow control
                        if (r_phase == PH_SEND) begin
                            do_cf = 1'b1;
                        end else begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            ACT_FC: begin
                if (r_phase == PH_WAIT_FC && i_fc_first_byte[7:4] == PCI_FC) begin
                    n_blk_limit = i_fc_block_size;
                    n_blk_count = '0;
                    n_phase     = PH_SEND;
                    cf_fill     = r_fill;
                    cf_buf      = r_buf;
                    cf_limit    = i_fc_block_size;
                    cf_count    = '0;
                    do_cf       = r_pending;
                end
            end
            default: ;
        endcase

        if (do_cf) begin
            res_valid   = 1'b1;
            res.id_word = id_word;
            res.kind    = KIND_CONSEC;
            res.data[0] = {PCI_CF, r_seq};
            for (int i = 0; i < BufDepth; i++) begin
                res.data[i+1] = (FillW'(i) < chunk && FillW'(i) < cf_fill) ? cf_buf[i]
                                                                          : r_pad_byte;
            end
            n_seq     = r_seq + 4'd1;
            n_rem     = r_rem - RemW'(chunk);
            n_fill    = '0;
            n_pending = 1'b0;
            res.last  = (n_rem == '0);
            if (n_rem == '0) begin
                n_phase = PH_IDLE;
            end else if (cf_limit != '0) begin
                n_blk_count = cf_count + 8'd1;
                if (n_blk_count >= cf_limit) begin
                    n_phase = PH_WAIT_FC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rem       <= '0;
            r_phase     <= PH_IDLE;
            r_seq       <= SEQ_RST;
            r_blk_limit <= '0;
            r_blk_count <= '0;
            r_pending   <= 1'b0;
        end else if (in_acc) begin
            r_fill      <= n_fill;
            r_rem       <= n_rem;
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_blk_limit <= n_blk_limit;
            r_blk_count <= n_blk_count;
            r_pending   <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && buf_wr) begin
            r_buf[r_fill] <= i_data_byte;
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc && res_valid;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= in_acc && res_valid;
        end else if (in_acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (!r_out_valid) begin
            r_out <= res;
        end else if (in_acc && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_id_word    = r_out.id_word;
    assign o_byte0      = r_out.data[0];
    assign o_byte1      = r_out.data[1];
    assign o_byte2      = r_out.data[2];
    assign o_byte3      = r_out.data[3];
    assign o_byte4      = r_out.data[4];
    assign o_byte5      = r_out.data[5];
    assign o_byte6      = r_out.data[6];
    assign o_byte7      = r_out.data[7];
    assign o_frame_kind = r_out.kind;
    assign o_last       = r_out.last;

    `ISTX_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ISTX_ASSERT_IMP(a_pending_waits_fc, i_clk, i_rst_n, r_pending, r_phase == PH_WAIT_FC)
    `ISTX_ASSERT_IMP(a_idle_empty_buf, i_clk, i_rst_n, r_phase == PH_IDLE, r_fill == '0)
    `ISTX_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n, r_out_valid && !i_out_ready && in_acc && res_valid, r_skid_valid)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for the ISO-TP transmit segmenter: random and directed words against a predictor.
// Depends on istx_pkg and isotp_tx_segmenter_unit; needs no files or arguments.
module testbench;
    import istx_pkg::*;

    // action code the segmenter ignores
    localparam logic [ActionW-1:0] ACT_RESERVED = 2'd3;

    typedef struct {
        logic [ActionW-1:0] action;
        logic [LenW-1:0]    len;
        logic [7:0]         data;
        logic [7:0]         fc_pci;
        logic [7:0]         fc_bs;
        int                 gap;
    } t_tx_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [ActionW-1:0] in_action = '0;
    logic [LenW-1:0]    in_msg_length = '0;
    logic [7:0]         in_data_byte = '0;
    logic [7:0]         in_fc_first_byte = '0;
    logic [7:0]         in_fc_block_size = '0;

    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [15:0]      out_id_word;
    logic [7:0]       out_byte [8];
    logic [KindW-1:0] out_kind;
    logic             out_last;

    isotp_tx_segmenter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (in_action),
        .i_msg_length    (in_msg_length),
        .i_data_byte     (in_data_byte),
        .i_fc_first_byte (in_fc_first_byte),
        .i_fc_block_size (in_fc_block_size),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_id_word       (out_id_word),
        .o_byte0         (out_byte[0]),
        .o_byte1         (out_byte[1]),
        .o_byte2         (out_byte[2]),
        .o_byte3         (out_byte[3]),
        .o_byte4         (out_byte[4]),
        .o_byte5         (out_byte[5]),
        .o_byte6         (out_byte[6]),
        .o_byte7         (out_byte[7]),
        .o_frame_kind    (out_kind),
        .o_last          (out_last)
    );

    // configuration as the segmenter should hold it
    logic [IdW-1:0]  cfg_target = TARGET_ID_RST;
    logic [DlcW-1:0] cfg_dlc = DLC_CODE_RST;
    logic [7:0]      cfg_pad = PAD_BYTE_RST;

    // segmentation state of the predictor
    logic [PhaseW-1:0] sg_phase = PH_IDLE;
    logic [7:0]        sg_buf [BufDepth] = '{default: 8'h00};
    int                sg_fill = 0;
    logic [RemW-1:0]   sg_remaining = '0;
    logic [3:0]        sg_seq = SEQ_RST;
    logic [7:0]        sg_block_limit = '0;
    logic [7:0]        sg_frames_in_block = '0;
    bit                sg_pending = 1'b0;

    t_tx_word words_to_send [$];
    t_frame   frames_due [$];
    t_tx_word cur_word;
    bit       word_in_flight = 1'b0;
    int       idle_cycles = 0;
    int       gap_max = 13;
    int       words_pushed = 0;

    int rx_stall = 0;
    int frames_seen = 0;
    int holds_done = 0;
    int n_errors = 0;

    function automatic t_frame empty_frame(input logic [KindW-1:0] kind);
        t_frame f;
        f = '0;
        f.kind = kind;
        return f;
    endfunction

    function automatic t_frame emit_consecutive();
        t_frame f;
        int chunk;
        chunk = (sg_remaining < 12'd7) ? int'(sg_remaining) : 7;
        f.id_word = {cfg_target, cfg_dlc};
        f.data[0] = {PCI_CF, sg_seq};
        for (int i = 0; i < 7; i++)
            f.data[i+1] = (i < chunk && i < sg_fill) ? sg_buf[i] : cfg_pad;
        f.kind = KIND_CONSEC;
        sg_seq = sg_seq + 4'd1;
        sg_remaining = sg_remaining - RemW'(chunk);
        sg_fill = 0;
        sg_pending = 1'b0;
        f.last = (sg_remaining == '0);
        if (f.last) begin
            sg_phase = PH_IDLE;
        end else if (sg_block_limit != 8'd0) begin
            sg_frames_in_block = sg_frames_in_block + 8'd1;
            if (sg_frames_in_block >= sg_block_limit)
                sg_phase = PH_WAIT_FC;
        end
        return f;
    endfunction

    // advance the segmenter state by one word; returns 1 when a frame is due
    function automatic bit segment_word(input t_tx_word w, output t_frame f);
        int chunk;
        f = '0;
        case (w.action)
            ACT_START: begin
                sg_fill = 0;
                sg_pending = 1'b0;
                sg_seq = SEQ_RST;
                sg_block_limit = '0;
                sg_frames_in_block = '0;
                if (w.len == '0 || w.len >= LenW'(4096)) begin
                    sg_phase = PH_IDLE;
                    sg_remaining = '0;
                    f = empty_frame(KIND_REJECT);
                    return 1'b1;
                end
                sg_remaining = w.len[RemW-1:0];
                sg_phase = (w.len <= LenW'(7)) ? PH_SF_FILL : PH_FF_FILL;
                return 1'b0;
            end
            ACT_BYTE: begin
                if (sg_phase == PH_IDLE || sg_pending) begin
                    f = empty_frame(KIND_OVERRUN);
                    return 1'b1;
                end
                if (sg_fill < 7)
                    sg_buf[sg_fill] = w.data;
                sg_fill++;
                if (sg_phase == PH_SF_FILL) begin
                    if (sg_fill < int'(sg_remaining))
                        return 1'b0;
                    f.id_word = {cfg_target, cfg_dlc};
                    f.data[0] = {4'h0, sg_remaining[3:0]};
                    for (int i = 0; i < 7; i++)
                        f.data[i+1] = (i < sg_fill) ? sg_buf[i] : cfg_pad;
                    f.kind = KIND_SINGLE;
                    f.last = 1'b1;
                    sg_phase = PH_IDLE;
                    sg_remaining = '0;
                    sg_fill = 0;
                    return 1'b1;
                end
                if (sg_phase == PH_FF_FILL) begin
                    if (sg_fill < 6)
                        return 1'b0;
                    f.id_word = {cfg_target, cfg_dlc};
                    f.data[0] = {PCI_FF, sg_remaining[11:8]};
                    f.data[1] = sg_remaining[7:0];
                    for (int i = 0; i < 6; i++)
                        f.data[i+2] = sg_buf[i];
                    f.kind = KIND_FIRST;
                    f.last = 1'b0;
                    sg_remaining = sg_remaining - RemW'(6);
                    sg_fill = 0;
                    sg_phase = PH_WAIT_FC;
                    return 1'b1;
                end
                // collecting a consecutive frame: send it or hold it for flow control
                chunk = (sg_remaining < 12'd7) ? int'(sg_remaining) : 7;
                if (sg_fill >= chunk) begin
                    if (sg_phase == PH_SEND) begin
                        f = emit_consecutive();
                        return 1'b1;
                    end
                    sg_pending = 1'b1;
                end
                return 1'b0;
            end
            ACT_FC: begin
                if (sg_phase != PH_WAIT_FC || w.fc_pci[7:4] != PCI_FC)
                    return 1'b0;
                sg_block_limit = w.fc_bs;
                sg_frames_in_block = '0;
                sg_phase = PH_SEND;
                if (sg_pending) begin
                    f = emit_consecutive();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_word(input logic [ActionW-1:0] act, input logic [LenW-1:0] len,
                                      input logic [7:0] d, input logic [7:0] pci,
                                      input logic [7:0] bs);
        t_tx_word w;
        w.action = act;
        w.len = len;
        w.data = d;
        w.fc_pci = pci;
        w.fc_bs = bs;
        w.gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        words_to_send.push_back(w);
        if (act != ACT_RESERVED)
            words_pushed++;
    endfunction

    function automatic void push_bytes(input int n);
        for (int i = 0; i < n; i++)
            push_word(ACT_BYTE, LenW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic void push_flow_control(input logic [7:0] bs);
        push_word(ACT_FC, LenW'($urandom), 8'($urandom), {PCI_FC, 4'($urandom)}, bs);
    endfunction

    // a message, with held frames, overruns and bad flow control mixed in; a bad length pushes only the start
    function automatic void push_message(input int len, input logic [7:0] bs, input bit abandon);
        int rem;
        int n;
        int k;
        push_word(ACT_START, LenW'(len), 8'($urandom), 8'($urandom), 8'($urandom));
        if (len == 0 || len >= 4096)
            return;
        if (len <= 7) begin
            push_bytes(len);
            return;
        end
        push_bytes(6);
        if (abandon)
            return;
        rem = len - 6;
        while (rem > 0) begin
            k = 0;
            if ($urandom_range(0, 3) == 0) begin
                k = (rem < 7) ? rem : 7;
                push_bytes(k);
                if ($urandom_range(0, 1) == 1)
                    push_bytes(1);
            end
            if ($urandom_range(0, 5) == 0)
                push_word(ACT_FC, LenW'($urandom), 8'($urandom),
                          {4'($urandom_range(0, 2)), 4'($urandom)}, 8'($urandom));
            push_flow_control(bs);
            n = (bs == 8'd0 || rem < int'(bs) * 7) ? rem : int'(bs) * 7;
            push_bytes(n - k);
            rem -= n;
        end
    endfunction

    function automatic void push_random_message();
        int r;
        int len;
        logic [7:0] bs;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: bs = 8'd0;
            4, 5, 6, 7: bs = 8'($urandom_range(1, 4));
            8: bs = 8'd255;
            default: bs = 8'($urandom);
        endcase
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        if (r < 35) begin
            push_message($urandom_range(1, 7), bs, 1'b0);
        end else if (r < 75) begin
            push_message($urandom_range(8, 50), bs, 1'b0);
        end else if (r < 85) begin
            push_message($urandom_range(51, 140), bs, 1'b0);
        end else if (r < 90) begin
            len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4096, 8191);
            push_message(len, bs, 1'b0);
        end else if (r < 95) begin
            case ($urandom_range(0, 2))
                0: push_bytes(1);
                1: push_word(ACT_FC, LenW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                default: push_word(ACT_RESERVED, LenW'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom));
            endcase
        end else begin
            push_message($urandom_range(8, 4095), bs, 1'b1);
        end
    endfunction

    task automatic wait_drained();
        while (words_to_send.size() != 0 || word_in_flight || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [ApbDataW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET_ID: cfg_target = val[IdW-1:0];
            REG_DLC_CODE:  cfg_dlc = val[DlcW-1:0];
            REG_PAD_BYTE:  cfg_pad = val[7:0];
            default: ;
        endcase
    endtask

    function automatic void flag_mismatch(input string what, input logic [15:0] want_v,
                                          input logic [15:0] got_v);
        n_errors++;
        if (n_errors <= 200)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // word driver
    always @(posedge i_clk) begin
        t_frame due;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            word_in_flight = 1'b0;
            idle_cycles = 0;
        end else begin
            if (in_valid && in_ready) begin
                word_in_flight = 1'b0;
                if (segment_word(cur_word, due))
                    frames_due.push_back(due);
            end
            if (!in_valid || in_ready) begin
                if (words_to_send.size() != 0 && idle_cycles >= words_to_send[0].gap) begin
                    cur_word = words_to_send.pop_front();
                    word_in_flight = 1'b1;
                    idle_cycles = 0;
                    in_valid <= 1'b1;
                    in_action <= cur_word.action;
                    in_msg_length <= cur_word.len;
                    in_data_byte <= cur_word.data;
                    in_fc_first_byte <= cur_word.fc_pci;
                    in_fc_block_size <= cur_word.fc_bs;
                end else begin
                    in_valid <= 1'b0;
                    idle_cycles++;
                end
            end
        end
    end

    // frame monitor and receiver stalls
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                got.id_word = out_id_word;
                for (int k = 0; k < 8; k++)
                    got.data[k] = out_byte[k];
                got.kind = out_kind;
                got.last = out_last;
                if (frames_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected frame, kind %0d id_word %h byte0 %h", $time,
                             got.kind, got.id_word, got.data[0]);
                end else begin
                    want = frames_due.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch("frame_kind", 16'(want.kind), 16'(got.kind));
                    if (got.id_word !== want.id_word)
                        flag_mismatch("id_word", want.id_word, got.id_word);
                    for (int k = 0; k < 8; k++)
                        if (got.data[k] !== want.data[k])
                            flag_mismatch($sformatf("byte%0d", k), 16'(want.data[k]),
                                          16'(got.data[k]));
                    if (got.last !== want.last)
                        flag_mismatch("last", 16'(want.last), 16'(got.last));
                end
                frames_seen++;
                // hold off for a long stretch while words are still queued, so the input stalls
                if (holds_done < 2 && frames_seen >= 40 * (holds_done + 1)
                        && words_to_send.size() > 40) begin
                    holds_done++;
                    rx_stall = 250;
                end else if ((frames_seen / 40) % 3 == 0) begin
                    rx_stall = 0;
                end else begin
                    rx_stall = $urandom_range(0, 13);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under reset configuration
        gap_max = 13;
        push_bytes(1);
        push_message(0, 8'd0, 1'b0);
        push_message(8191, 8'd0, 1'b0);
        push_word(ACT_RESERVED, LenW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        push_flow_control(8'd0);
        push_word(ACT_START, LenW'(1), 8'hFF, 8'hFF, 8'hFF);
        push_word(ACT_BYTE, '1, 8'h00, 8'h00, 8'h00);
        push_message(4095, 8'd0, 1'b1);
        push_message(9, 8'd0, 1'b1);
        push_word(ACT_FC, '0, 8'h00, 8'h2F, 8'h01);
        push_word(ACT_BYTE, '0, 8'hFF, 8'h00, 8'h00);
        push_bytes(2);
        push_bytes(1);
        push_word(ACT_FC, '0, 8'h00, {PCI_FC, 4'h0}, 8'hFF);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_TARGET_ID, 32'd2047);
                    apb_write(REG_DLC_CODE, 32'd31);
                    apb_write(REG_PAD_BYTE, 32'hFF);
                end
                1: begin
                    apb_write(REG_TARGET_ID, 32'd0);
                    apb_write(REG_DLC_CODE, 32'd0);
                    apb_write(REG_PAD_BYTE, 32'h00);
                end
                default: begin
                    apb_write(REG_TARGET_ID, $urandom_range(0, 2047));
                    apb_write(REG_DLC_CODE, $urandom_range(0, 31));
                    apb_write(REG_PAD_BYTE, $urandom_range(0, 255));
                end
            endcase
            // two batches; the sender pauses between them until every frame is in
            for (int half = 0; half < 2; half++) begin
                target = words_pushed + 70;
                while (words_pushed < target)
                    push_random_message();
                wait_drained();
            end
        end

        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
